/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ssc_pkg.sv */
package ssc_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int SEL_W      = 7;
    localparam int CMD_W      = 2;
    localparam int MEAS_FIELDS = 6;

    // Input tdata layout, lowest bit first.
    localparam int SEL_LSB    = 0;
    localparam int VALUE_LSB  = SEL_LSB + SEL_W;
    localparam int MEAS_LSB   = VALUE_LSB + DATA_W;
    localparam int IN_BITS    = MEAS_LSB + MEAS_FIELDS * DATA_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    // Microprogram counter and step addresses.
    typedef logic [2:0] t_pc;
    localparam t_pc PC_FETCH  = 3'd0;
    localparam t_pc PC_LOAD   = 3'd1;
    localparam t_pc PC_CLEAR  = 3'd2;
    localparam t_pc PC_START  = 3'd3;
    localparam t_pc PC_MAC    = 3'd4;
    localparam t_pc PC_DRAIN  = 3'd5;
    localparam t_pc PC_COMMIT = 3'd6;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_CLEAR,
        UOP_START,
        UOP_MAC,
        UOP_COMMIT
    } t_uop;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_DISPATCH,
        JC_MAC_MORE,
        JC_PIPE_BUSY,
        JC_OUT_BUSY
    } t_jcond;

    // When the condition holds the sequencer goes to target, otherwise to next.
    typedef struct packed {
        t_uop   op;
        t_jcond cond;
        t_pc    target;
        t_pc    next;
    } t_uword;

    typedef struct packed {
        logic             item_valid;
        logic [CMD_W-1:0] cmd;
        logic             mem_busy;
        logic             mac_last;
        logic             pipe_busy;
        logic             out_busy;
    } t_seq_status;

    typedef struct packed {
        t_uop op;
        logic ready;
        logic accept;
    } t_seq_ctrl;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_FETCH:  w = '{UOP_NOP,    JC_DISPATCH,  PC_FETCH,  PC_FETCH};
            PC_LOAD:   w = '{UOP_LOAD,   JC_NEXT,      PC_FETCH,  PC_FETCH};
            PC_CLEAR:  w = '{UOP_CLEAR,  JC_NEXT,      PC_FETCH,  PC_FETCH};
            PC_START:  w = '{UOP_START,  JC_NEXT,      PC_MAC,    PC_MAC};
            PC_MAC:    w = '{UOP_MAC,    JC_MAC_MORE,  PC_MAC,    PC_DRAIN};
            PC_DRAIN:  w = '{UOP_NOP,    JC_PIPE_BUSY, PC_DRAIN,  PC_COMMIT};
            PC_COMMIT: w = '{UOP_COMMIT, JC_OUT_BUSY,  PC_COMMIT, PC_FETCH};
            default:   w = '{UOP_NOP,    JC_NEXT,      PC_FETCH,  PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/ssc_seq.sv */
module ssc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssc_pkg::t_seq_status i_status,
    output ssc_pkg::t_seq_ctrl   o_ctrl
);
    import ssc_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_ready;
    logic   w_accept;

    always_comb begin
        w_word   = ucode_rom(r_pc);
        w_ready  = (w_word.cond == JC_DISPATCH) && !i_status.mem_busy;
        w_accept = w_ready && i_status.item_valid;
        n_pc     = w_word.next;
        unique case (w_word.cond)
            JC_DISPATCH: begin
                if (w_accept) begin
                    unique case (i_status.cmd)
                        CMD_LOAD:   n_pc = PC_LOAD;
                        CMD_SAMPLE: n_pc = PC_START;
                        CMD_CLEAR:  n_pc = PC_CLEAR;
                        default:    n_pc = PC_FETCH;
                    endcase
                end else begin
                    n_pc = w_word.target;
                end
            end
            JC_MAC_MORE:  n_pc = i_status.mac_last ? w_word.next : w_word.target;
            JC_PIPE_BUSY: n_pc = i_status.pipe_busy ? w_word.target : w_word.next;
            JC_OUT_BUSY:  n_pc = i_status.out_busy ? w_word.target : w_word.next;
            default:      n_pc = w_word.next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op     = w_word.op;
    assign o_ctrl.ready  = w_ready;
    assign o_ctrl.accept = w_accept;

endmodule

/* rtl/core/state_space_controller_step_unit.sv */
// Discrete state-space controller step, signed Q16.16.
// Slave channel s_axis: tuser carries the command (load coefficient, sample,
// clear state), tdata the coefficient address, coefficient word and six
// measurements. Master channel m_axis: one item per sample, tdata the drive
// value and tuser the clip flag. Loads and clears give no output item.
// A load or a clear goes through its own microcode step and then back to
// fetch. A sample runs on one shared multiplier-accumulator fed from the
// coefficient memory, one product per cycle; the next item is taken only
// after the products have drained and the result has been committed to the
// output register, where the output item then becomes valid.
// After reset the coefficient memory is swept to zero, one word a cycle,
// through all COEF_TOTAL words (84 words at the defaults); no item is taken then.
// The controller state is zero after reset. The output register holds its
// item while m_axis_tready is low; loads and clears are still accepted
// meanwhile, but a following sample waits in its final step and blocks them.
`include "assert_macros.svh"

module state_space_controller_step_unit #(
    parameter int CTRL_ORDER = 6,
    parameter int MEAS_DIM   = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // coef_sel, coef_value, meas_0 .. meas_5, zero padding
    input  logic [ssc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic [ssc_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drive
    output logic [ssc_pkg::DATA_W-1:0]         m_axis_tdata,
    // saturated
    output logic [0:0]                         m_axis_tuser
);
    import ssc_pkg::*;

    localparam int BK_BASE    = CTRL_ORDER * CTRL_ORDER;
    localparam int CK_BASE    = BK_BASE + CTRL_ORDER * MEAS_DIM;
    localparam int DK_BASE    = CK_BASE + CTRL_ORDER;
    localparam int COEF_TOTAL = DK_BASE + MEAS_DIM;
    localparam int CW         = $clog2(COEF_TOTAL);
    localparam int SELX_W     = ((CW > SEL_W) ? CW : SEL_W) + 1;
    localparam int TERMS      = CTRL_ORDER + MEAS_DIM;
    localparam int CLW        = $clog2(TERMS);
    localparam int RW         = $clog2(CTRL_ORDER + 1);
    localparam int XIW        = (CTRL_ORDER > 1) ? $clog2(CTRL_ORDER) : 1;
    localparam int MIW        = (MEAS_DIM > 1) ? $clog2(MEAS_DIM) : 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W + 2 + $clog2(TERMS);
    localparam int RES_MSB    = FRAC_W + DATA_W - 1;

    t_seq_status w_status;
    t_seq_ctrl   w_ctrl;

    // Coefficient memory and its clearing sweep.
    logic [DATA_W-1:0] r_coef_mem [COEF_TOTAL];
    logic [DATA_W-1:0] r_coef_rd;
    logic              r_clr_busy;
    logic [CW-1:0]     r_clr_addr;

    // Captured item.
    logic [SEL_W-1:0]  r_sel;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_meas [MEAS_DIM];

    // Controller state and results in progress.
    logic [DATA_W-1:0] r_x    [CTRL_ORDER];
    logic [DATA_W-1:0] r_next [CTRL_ORDER];
    logic [DATA_W-1:0] r_drive_buf;
    logic              r_sat;

    // Issue counters and coefficient pointers.
    logic [RW-1:0]     r_row;
    logic [CLW-1:0]    r_col;
    logic [CW-1:0]     r_ptr_a;
    logic [CW-1:0]     r_ptr_b;

    // MAC pipeline.
    logic              r1_valid;
    logic              r1_first;
    logic              r1_last;
    logic [RW-1:0]     r1_row;
    logic [DATA_W-1:0] r1_opnd;
    logic              r2_valid;
    logic              r2_first;
    logic              r2_last;
    logic [RW-1:0]     r2_row;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r3_done;
    logic [RW-1:0]     r3_row;

    // Output register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_drive;
    logic              r_out_sat;

    logic              w_col_is_x;
    logic              w_col_last;
    logic              w_mac_last;
    logic [CW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_opnd;
    logic              w_pipe_busy;
    logic              w_out_busy;
    logic              w_mac_en;
    logic              w_commit_en;
    logic              w_sel_ok;
    logic              w_mem_we;
    logic [CW-1:0]     w_mem_wa;
    logic [DATA_W-1:0] w_mem_wd;
    logic [ACC_W-1:0]  w_prod_ext;
    logic [ACC_W-RES_MSB-1:0] w_acc_top;
    logic              w_fits;
    logic [DATA_W-1:0] w_acc_q;

    always_comb begin
        w_col_is_x  = r_col < CLW'(CTRL_ORDER);
        w_col_last  = r_col == CLW'(TERMS - 1);
        w_mac_last  = w_col_last && (r_row == RW'(CTRL_ORDER));
        w_rd_addr   = w_col_is_x ? r_ptr_a : r_ptr_b;
        w_opnd      = w_col_is_x ? r_x[XIW'(r_col)]
                                 : r_meas[MIW'(r_col - CLW'(CTRL_ORDER))];
        w_pipe_busy = r1_valid || r2_valid || r3_done;
        w_out_busy  = r_out_valid && !m_axis_tready;
        w_mac_en    = w_ctrl.op == UOP_MAC;
        w_commit_en = (w_ctrl.op == UOP_COMMIT) && !w_out_busy;
        w_sel_ok    = SELX_W'(r_sel) < SELX_W'(COEF_TOTAL);
        w_mem_we    = r_clr_busy || ((w_ctrl.op == UOP_LOAD) && w_sel_ok);
        w_mem_wa    = r_clr_busy ? r_clr_addr : CW'(r_sel);
        w_mem_wd    = r_clr_busy ? '0 : r_value;
        w_prod_ext  = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        // Rounding was folded into the accumulator start value, so only the
        // range check is left: the result's sign bit and the bits above it must agree.
        w_acc_top   = r_acc[ACC_W-1:RES_MSB];
        w_fits      = (&w_acc_top) || !(|w_acc_top);
        if (w_fits) begin
            w_acc_q = r_acc[RES_MSB:FRAC_W];
        end else begin
            w_acc_q = r_acc[ACC_W-1] ? Q_MIN : Q_MAX;
        end
    end

    assign w_status.item_valid = s_axis_tvalid;
    assign w_status.cmd        = s_axis_tuser;
    assign w_status.mem_busy   = r_clr_busy;
    assign w_status.mac_last   = w_mac_last;
    assign w_status.pipe_busy  = w_pipe_busy;
    assign w_status.out_busy   = w_out_busy;

    ssc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_coef_mem[w_mem_wa] <= w_mem_wd;
        end
        r_coef_rd <= r_coef_mem[w_rd_addr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_done     <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            for (int i = 0; i < CTRL_ORDER; i++) begin
                r_x[i] <= '0;
            end
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == CW'(COEF_TOTAL - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r1_valid <= w_mac_en;
            r2_valid <= r1_valid;
            r3_done  <= r2_valid && r2_last;
            if (w_ctrl.op == UOP_START) begin
                r_row <= '0;
                r_col <= '0;
            end else if (w_mac_en) begin
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (w_ctrl.op == UOP_CLEAR) begin
                for (int i = 0; i < CTRL_ORDER; i++) begin
                    r_x[i] <= '0;
                end
            end else if (w_commit_en) begin
                r_x <= r_next;
            end
            // A new item may be committed in the cycle the held one leaves.
            r_out_valid <= w_commit_en || (r_out_valid && !m_axis_tready);
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_sel   <= s_axis_tdata[SEL_LSB +: SEL_W];
            r_value <= s_axis_tdata[VALUE_LSB +: DATA_W];
            for (int k = 0; k < MEAS_DIM; k++) begin
                r_meas[k] <= s_axis_tdata[MEAS_LSB + k * DATA_W +: DATA_W];
            end
        end

        // The drive row walks Ck then Dk; after it both pointers restart
        // on the Ak and Bk rows, which are contiguous from then on.
        if (w_ctrl.op == UOP_START) begin
            r_ptr_a <= CW'(CK_BASE);
            r_ptr_b <= CW'(DK_BASE);
        end else if (w_mac_en) begin
            if (w_col_last && (r_row == '0)) begin
                r_ptr_a <= '0;
                r_ptr_b <= CW'(BK_BASE);
            end else if (w_col_is_x) begin
                r_ptr_a <= r_ptr_a + 1'b1;
            end else begin
                r_ptr_b <= r_ptr_b + 1'b1;
            end
        end

        r1_first <= r_col == '0;
        r1_last  <= w_col_last;
        r1_row   <= r_row;
        r1_opnd  <= w_opnd;

        r2_first <= r1_first;
        r2_last  <= r1_last;
        r2_row   <= r1_row;
        r_prod   <= $signed(r_coef_rd) * $signed(r1_opnd);

        if (r2_valid) begin
            if (r2_first) begin
                r_acc <= (ACC_W'(1) << (FRAC_W - 1)) + w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
        r3_row <= r2_row;

        if (w_ctrl.op == UOP_START) begin
            r_sat <= 1'b0;
        end else if (r3_done) begin
            r_sat <= r_sat || !w_fits;
        end
        if (r3_done) begin
            if (r3_row == '0) begin
                r_drive_buf <= w_acc_q;
            end else begin
                r_next[XIW'(r3_row - 1'b1)] <= w_acc_q;
            end
        end

        if (w_commit_en) begin
            r_out_drive <= r_drive_buf;
            r_out_sat   <= r_sat;
        end
    end

    assign s_axis_tready = w_ctrl.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_drive;
    assign m_axis_tuser  = r_out_sat;

    `SSC_ASSERT_IMPLY(a_no_accept_in_sweep, i_clk, i_rst_n, r_clr_busy, !s_axis_tready, "item taken during coefficient sweep")
    `SSC_ASSERT_IMPLY(a_commit_after_drain, i_clk, i_rst_n, w_commit_en, !w_pipe_busy, "result committed with products still in flight")
    `SSC_ASSERT_IMPLY(a_finish_in_sample, i_clk, i_rst_n, r3_done, (w_ctrl.op == UOP_MAC) || (w_ctrl.op == UOP_NOP), "row finished outside a sample")
    `SSC_ASSERT_NEXT(a_sweep_blocks_mac, i_clk, i_rst_n, r_clr_busy, !r1_valid, "product issued during coefficient sweep")

endmodule

/* verif/tb_state_space_controller_step_unit.sv */
`timescale 1ns / 1ps

module tb_state_space_controller_step_unit;
    import ssc_pkg::*;

    localparam int ORDER      = 6;
    localparam int MDIM       = 6;
    localparam int BK_BASE    = ORDER * ORDER;
    localparam int CK_BASE    = BK_BASE + ORDER * MDIM;
    localparam int DK_BASE    = CK_BASE + ORDER;
    localparam int COEF_TOTAL = DK_BASE + MDIM;

    // The command field has one code that the block does not use.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 120;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;
    localparam logic signed [79:0] ACC_LIMIT = 80'sd1 <<< 47;

    typedef logic [MEAS_FIELDS*DATA_W-1:0] t_meas_vec;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              clipped;
    } t_drive_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // coef_sel, coef_value, meas_0 .. meas_5, zero padding
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // cmd
    logic [CMD_W-1:0]       s_axis_tuser = CMD_LOAD;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // drive
    logic [DATA_W-1:0]      m_axis_tdata;
    // saturated
    logic [0:0]             m_axis_tuser;

    // Shadow copy of the controller: coefficient memory and state vector.
    logic [DATA_W-1:0] coef_mem [COEF_TOTAL];
    logic [DATA_W-1:0] ctrl_x [ORDER];
    t_drive_item       pending_drives [$];
    t_drive_item       want;

    int send_idle_pct = 14;
    int recv_idle_pct = 72;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int samples_sent = 0;
    int drives_checked = 0;
    int clipped_seen = 0;
    int failures = 0;
    int cycle_count = 0;

    state_space_controller_step_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                $error("drive item with none expected: drive %h saturated %b",
                       m_axis_tdata, m_axis_tuser);
                failures++;
            end else begin
                want = pending_drives.pop_front();
                if (m_axis_tdata !== want.drive) begin
                    $error("drive: expected %h, got %h", want.drive, m_axis_tdata);
                    failures++;
                end
                if (m_axis_tuser[0] !== want.clipped) begin
                    $error("saturated: expected %b, got %b", want.clipped, m_axis_tuser[0]);
                    failures++;
                end
                if (want.clipped)
                    clipped_seen++;
            end
            drives_checked++;
        end
    end

    function automatic logic signed [79:0] q_product(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
        longint p;
        p = longint'($signed(a)) * longint'($signed(b));
        return 80'(p);
    endfunction

    // Round to nearest with ties upward, then clip to 32 bits; bit 32 flags a clip.
    function automatic logic [DATA_W:0] round_to_q(input logic signed [79:0] acc);
        logic signed [79:0] r;
        r = acc + 80'sd32768;
        if (r >= ACC_LIMIT)
            return {1'b1, Q_MAX};
        if (r < -ACC_LIMIT)
            return {1'b1, Q_MIN};
        return {1'b0, r[47:16]};
    endfunction

    // One controller step: the drive uses the old state, and every new state
    // row is formed from the old state before any is written back.
    function automatic t_drive_item controller_step(input t_meas_vec meas);
        logic signed [79:0] acc;
        logic [DATA_W:0]    rs;
        logic [DATA_W-1:0]  next_x [ORDER];
        t_drive_item        res;
        acc = '0;
        for (int c = 0; c < ORDER; c++)
            acc = acc + q_product(coef_mem[CK_BASE + c], ctrl_x[c]);
        for (int c = 0; c < MDIM; c++)
            acc = acc + q_product(coef_mem[DK_BASE + c], meas[c*DATA_W +: DATA_W]);
        rs = round_to_q(acc);
        res.drive = rs[DATA_W-1:0];
        res.clipped = rs[DATA_W];
        for (int r = 0; r < ORDER; r++) begin
            acc = '0;
            for (int c = 0; c < ORDER; c++)
                acc = acc + q_product(coef_mem[r*ORDER + c], ctrl_x[c]);
            for (int c = 0; c < MDIM; c++)
                acc = acc + q_product(coef_mem[BK_BASE + r*MDIM + c],
                                      meas[c*DATA_W +: DATA_W]);
            rs = round_to_q(acc);
            next_x[r] = rs[DATA_W-1:0];
            res.clipped = res.clipped | rs[DATA_W];
        end
        for (int r = 0; r < ORDER; r++)
            ctrl_x[r] = next_x[r];
        return res;
    endfunction

    task automatic send_command(input logic [CMD_W-1:0]  cmd,
                                input logic [SEL_W-1:0]  sel,
                                input logic [DATA_W-1:0] value,
                                input t_meas_vec         meas);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        gap = 0;
        if (send_idle_pct != 0) begin
            if ($urandom_range(99) < 3)
                gap = $urandom_range(100, 1);
            else
                while ($urandom_range(99) < send_idle_pct && gap < 40)
                    gap++;
        end
        word = '0;
        word[SEL_LSB +: SEL_W] = sel;
        word[VALUE_LSB +: DATA_W] = value;
        word[MEAS_LSB +: MEAS_FIELDS*DATA_W] = meas;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        case (cmd)
            CMD_LOAD: begin
                if (sel < COEF_TOTAL)
                    coef_mem[sel] = value;
            end
            CMD_CLEAR: begin
                for (int r = 0; r < ORDER; r++)
                    ctrl_x[r] = '0;
            end
            CMD_SAMPLE: begin
                pending_drives.push_back(controller_step(meas));
                samples_sent++;
            end
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic wait_for_drives();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_q(input int span);
        int                pick;
        logic [DATA_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 8)
            return $urandom;
        if (pick < 12)
            return pick[0] ? Q_MAX : Q_MIN;
        v = $urandom_range(2 * span);
        return v - span;
    endfunction

    function automatic t_meas_vec random_meas(input int span);
        t_meas_vec v;
        for (int k = 0; k < MEAS_FIELDS; k++)
            v[k*DATA_W +: DATA_W] = random_q(span);
        return v;
    endfunction

    // Small state-matrix entries keep the loop mostly out of saturation.
    function automatic logic [DATA_W-1:0] random_coef(input logic [SEL_W-1:0] sel);
        return random_q((sel < BK_BASE) ? 32'h1800 : Q_HALF);
    endfunction

    task automatic test_directed();
        t_meas_vec zero_meas;
        t_meas_vec unit_meas;
        t_meas_vec tie_up;
        t_meas_vec tie_down;
        zero_meas = '0;
        unit_meas = '0;
        unit_meas[0 +: DATA_W] = Q_ONE;
        tie_up = '0;
        tie_up[0 +: DATA_W] = 32'h0000_0001;
        tie_down = '0;
        tie_down[0 +: DATA_W] = 32'hFFFF_FFFF;
        // Coefficients are all zero straight after reset.
        send_command(CMD_SAMPLE, '0, '0, {MEAS_FIELDS{Q_MAX}});
        send_command(CMD_LOAD, '0, Q_ONE, zero_meas);
        send_command(CMD_LOAD, SEL_W'(BK_BASE), Q_ONE, zero_meas);
        send_command(CMD_LOAD, SEL_W'(CK_BASE), Q_ONE, zero_meas);
        send_command(CMD_LOAD, SEL_W'(DK_BASE), Q_HALF, zero_meas);
        send_command(CMD_LOAD, SEL_W'(COEF_TOTAL - 1), Q_MIN, zero_meas);
        // Addresses past the coefficient layout must leave the memory alone.
        send_command(CMD_LOAD, SEL_W'(COEF_TOTAL), Q_MAX, zero_meas);
        send_command(CMD_LOAD, '1, Q_MAX, {MEAS_FIELDS{Q_MAX}});
        send_command(CMD_SAMPLE, '0, '0, unit_meas);
        send_command(CMD_SAMPLE, '0, '0, unit_meas);
        send_command(CMD_SPARE, '0, Q_MAX, unit_meas);
        send_command(CMD_SAMPLE, '1, '1, {MEAS_FIELDS{Q_MAX}});
        send_command(CMD_SAMPLE, '0, '0, {MEAS_FIELDS{Q_MIN}});
        send_command(CMD_CLEAR, '0, '0, zero_meas);
        send_command(CMD_SAMPLE, '0, '0, unit_meas);
        // Half-way products: a positive tie rounds up, a negative one to zero.
        send_command(CMD_CLEAR, '1, '1, {MEAS_FIELDS{Q_MAX}});
        send_command(CMD_SAMPLE, '0, '0, tie_up);
        send_command(CMD_CLEAR, '0, '0, zero_meas);
        send_command(CMD_SAMPLE, '0, '0, tie_down);
        send_command(CMD_SAMPLE, '0, '0, zero_meas);
        wait_for_drives();
    endtask

    // Mostly coherent programmes (some loads, maybe a clear, then samples),
    // with the odd burst of arbitrary items in between.
    task automatic run_programs(input int count);
        int               stop_at;
        logic [SEL_W-1:0] sel;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                repeat ($urandom_range(16, 1)) begin
                    sel = SEL_W'($urandom_range(COEF_TOTAL - 1));
                    send_command(CMD_LOAD, sel, random_coef(sel), random_meas(Q_ONE));
                end
                if ($urandom_range(99) < 25)
                    send_command(CMD_CLEAR, SEL_W'($urandom), $urandom,
                                 random_meas(Q_ONE));
                repeat ($urandom_range(6, 1))
                    send_command(CMD_SAMPLE, SEL_W'($urandom), $urandom,
                                 random_meas(2 * Q_ONE));
            end else begin
                repeat (4)
                    send_command(CMD_W'($urandom_range(CMD_SPARE)), SEL_W'($urandom),
                                 $urandom, random_meas(1 << 29));
            end
        end
    endtask

    task automatic test_output_backpressure();
        hold_reqs++;
        repeat (8)
            send_command(CMD_SAMPLE, '0, '0, random_meas(Q_ONE));
        send_command(CMD_LOAD, SEL_W'($urandom_range(COEF_TOTAL - 1)), Q_HALF, '0);
        wait_for_drives();
        // The sender has sat idle until every drive value came back.
        repeat (3)
            send_command(CMD_SAMPLE, '0, '0, random_meas(Q_ONE));
        wait_for_drives();
    endtask

    initial begin
        for (int i = 0; i < COEF_TOTAL; i++)
            coef_mem[i] = '0;
        for (int r = 0; r < ORDER; r++)
            ctrl_x[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        run_programs(360);
        wait_for_drives();

        send_idle_pct = 72;
        recv_idle_pct = 14;
        run_programs(360);
        wait_for_drives();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_programs(330);
        test_output_backpressure();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items, %0d of them samples; checked %0d drive values (%0d clipped).",
                 items_sent, samples_sent, drives_checked, clipped_seen);
        $display("Covered loads in and out of range, clears, the spare command and hold-off.");
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_seq.sv
rtl/core/state_space_controller_step_unit.sv
verif/tb_state_space_controller_step_unit.sv
